@@ src/pfr_pkg.sv @@
// Shared types and constants for the packet frame receiver.
// Holds the controller states, register indexes and the command/status structs.
// No dependencies.
package pfr_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 7;
	localparam int IDX_W     = 6;
	localparam int CFG_IDX_W = 2;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HEADER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HEADER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd2;

	// Register reset values
	localparam logic [BYTE_W-1:0] FIRST_HEADER_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'h55;
	localparam logic [LEN_W-1:0]  MAX_LENGTH_RST    = 7'd64;

	typedef enum logic [3:0] {
		ST_HUNT1,
		ST_HUNT2,
		ST_TYPE,
		ST_CMD,
		ST_LEN,
		ST_DATA,
		ST_SUM,
		ST_RD_REQ,
		ST_RD_LOAD
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic type_load;   // take device type, restart checksum
		logic cmd_load;    // take command byte
		logic len_load;    // take length byte, clear fill index
		logic data_load;   // store payload byte
		logic rd_start;    // clear readout index
		logic rd_issue;    // read buffer at readout index
		logic rd_load;     // move buffer word to output register
		logic empty_load;  // output register gets the empty-frame result
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_first;    // input byte matches first header
		logic is_second;   // input byte matches second header
		logic len_over;    // input length above the effective limit
		logic len_zero;    // input length is zero
		logic fill_done;   // this payload byte is the frame's last
		logic sum_ok;      // input byte matches inverted running sum
		logic held_zero;   // held length is zero
		logic rd_last;     // current readout word is the frame's last
		logic out_busy;    // output register holds an untaken word
		logic out_free;    // output register free in this cycle
	} dp_stat_t;

endpackage

@@ src/pfr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the payload buffer. No dependencies.
module pfr_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/pfr_ctrl.sv @@
// Frame parser controller: header hunt, field sequencing and buffer readout.
// Depends on pfr_pkg; drives the datapath through dp_cmd_t, reads dp_stat_t.
module pfr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output pfr_pkg::dp_cmd_t  cmd,
	input  pfr_pkg::dp_stat_t stat
);
	import pfr_pkg::*;

	state_t state_q, state_nx;
	logic   in_fire;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_HUNT1;
		else
			state_q <= state_nx;
	end

	// Input handshake: checksum byte waits until the output register is empty
	always_comb begin
		unique case (state_q)
			ST_HUNT1, ST_HUNT2, ST_TYPE, ST_CMD, ST_LEN, ST_DATA: in_ready = 1'b1;
			ST_SUM:                                              in_ready = !stat.out_busy;
			default:                                             in_ready = 1'b0;
		endcase
	end

	assign in_fire = in_valid && in_ready;

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_HUNT1: if (in_fire && stat.is_first) state_nx = ST_HUNT2;
			ST_HUNT2: begin
				if (in_fire) begin
					if (stat.is_second)
						state_nx = ST_TYPE;
					else if (!stat.is_first)
						state_nx = ST_HUNT1;
				end
			end
			ST_TYPE: if (in_fire) state_nx = ST_CMD;
			ST_CMD:  if (in_fire) state_nx = ST_LEN;
			ST_LEN: begin
				if (in_fire) begin
					if (stat.len_over)
						state_nx = ST_HUNT1;
					else if (stat.len_zero)
						state_nx = ST_SUM;
					else
						state_nx = ST_DATA;
				end
			end
			ST_DATA: if (in_fire && stat.fill_done) state_nx = ST_SUM;
			ST_SUM: begin
				if (in_fire) begin
					if (stat.sum_ok && !stat.held_zero)
						state_nx = ST_RD_REQ;
					else
						state_nx = ST_HUNT1;
				end
			end
			ST_RD_REQ:  if (stat.out_free) state_nx = ST_RD_LOAD;
			ST_RD_LOAD: state_nx = stat.rd_last ? ST_HUNT1 : ST_RD_REQ;
			default:    state_nx = ST_HUNT1;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_TYPE: cmd.type_load = in_fire;
			ST_CMD:  cmd.cmd_load  = in_fire;
			ST_LEN:  cmd.len_load  = in_fire;
			ST_DATA: cmd.data_load = in_fire;
			ST_SUM: begin
				cmd.rd_start   = in_fire;
				cmd.empty_load = in_fire && stat.sum_ok && stat.held_zero;
			end
			ST_RD_REQ:  cmd.rd_issue = stat.out_free;
			ST_RD_LOAD: cmd.rd_load  = 1'b1;
			default:    cmd = '0;
		endcase
	end

	// No input word is taken while the buffer is being read out
	a_no_input_in_readout: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_REQ || state_q == ST_RD_LOAD) |-> !in_ready)
		else $error("input accepted during readout");

	// A buffer read is always followed by the output load
	a_issue_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |=> cmd.rd_load)
		else $error("buffer read not followed by output load");

	// Readout only starts after a good checksum on a nonempty frame
	a_readout_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM && state_nx == ST_RD_REQ) |-> (stat.sum_ok && !stat.held_zero))
		else $error("readout started without a good checksum");

endmodule

@@ src/pfr_dp.sv @@
// Frame parser datapath: config registers, header/length checks, running sum,
// payload buffer and output register. Depends on pfr_pkg and pfr_ram.
module pfr_dp #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfr_pkg::BYTE_W-1:0]    cfg_data,
	input  logic [pfr_pkg::BYTE_W-1:0]    rx_byte,
	input  pfr_pkg::dp_cmd_t              cmd,
	output pfr_pkg::dp_stat_t             stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pfr_pkg::BYTE_W-1:0]    device_type,
	output logic [pfr_pkg::BYTE_W-1:0]    command,
	output logic [pfr_pkg::LEN_W-1:0]     payload_length,
	output logic [pfr_pkg::IDX_W-1:0]     byte_index,
	output logic [pfr_pkg::BYTE_W-1:0]    payload_byte,
	output logic                          has_payload,
	output logic                          last
);
	import pfr_pkg::*;

	localparam int               ADDR_W    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUFFER_DEPTH);

	logic [BYTE_W-1:0] first_hdr_q, second_hdr_q;
	logic [LEN_W-1:0]  max_len_q;
	logic [BYTE_W-1:0] sum_q, type_q, cmd_q;
	logic [LEN_W-1:0]  len_q, fill_q, rd_q;
	logic [LEN_W-1:0]  limit, fill_inc, rd_inc;
	logic [BYTE_W-1:0] ram_rdata;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_type_q, out_cmd_q, out_byte_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_has_q, out_last_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_hdr_q  <= FIRST_HEADER_RST;
			second_hdr_q <= SECOND_HEADER_RST;
			max_len_q    <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIRST_HEADER:  first_hdr_q  <= cfg_data;
				CFG_SECOND_HEADER: second_hdr_q <= cfg_data;
				CFG_MAX_LENGTH:    max_len_q    <= cfg_data[LEN_W-1:0];
				default:           ;
			endcase
		end
	end

	// Length limit saturates at the buffer depth
	assign limit    = (max_len_q > DEPTH_LEN) ? DEPTH_LEN : max_len_q;
	assign fill_inc = fill_q + LEN_W'(1);
	assign rd_inc   = rd_q + LEN_W'(1);

	// Frame fields, running sum and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			type_q <= '0;
			cmd_q  <= '0;
			len_q  <= '0;
			fill_q <= '0;
			rd_q   <= '0;
		end else begin
			if (cmd.type_load) begin
				sum_q  <= rx_byte;
				type_q <= rx_byte;
			end
			if (cmd.cmd_load || cmd.len_load || cmd.data_load)
				sum_q <= sum_q + rx_byte;
			if (cmd.cmd_load)
				cmd_q <= rx_byte;
			if (cmd.len_load) begin
				fill_q <= '0;
				if (!stat.len_over)
					len_q <= rx_byte[LEN_W-1:0];
			end
			if (cmd.data_load)
				fill_q <= fill_inc;
			if (cmd.rd_start)
				rd_q <= '0;
			else if (cmd.rd_load)
				rd_q <= rd_inc;
		end
	end

	// Payload buffer
	pfr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BUFFER_DEPTH),
		.ADDR_W(ADDR_W)
	) u_buf (
		.clk  (clk),
		.we   (cmd.data_load),
		.waddr(fill_q[ADDR_W-1:0]),
		.wdata(rx_byte),
		.re   (cmd.rd_issue),
		.raddr(rd_q[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.rd_load || cmd.empty_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.rd_load || cmd.empty_load) begin
			out_type_q <= type_q;
			out_cmd_q  <= cmd_q;
		end
		if (cmd.rd_load) begin
			out_len_q  <= len_q;
			out_idx_q  <= rd_q[IDX_W-1:0];
			out_byte_q <= ram_rdata;
			out_has_q  <= 1'b1;
			out_last_q <= (rd_inc == len_q);
		end else if (cmd.empty_load) begin
			out_len_q  <= '0;
			out_idx_q  <= '0;
			out_byte_q <= '0;
			out_has_q  <= 1'b0;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign device_type    = out_type_q;
	assign command        = out_cmd_q;
	assign payload_length = out_len_q;
	assign byte_index     = out_idx_q;
	assign payload_byte   = out_byte_q;
	assign has_payload    = out_has_q;
	assign last           = out_last_q;

	// Status to the controller
	always_comb begin
		stat.is_first  = (rx_byte == first_hdr_q);
		stat.is_second = (rx_byte == second_hdr_q);
		stat.len_over  = (rx_byte > {1'b0, limit});
		stat.len_zero  = (rx_byte == '0);
		stat.fill_done = (fill_inc >= len_q);
		stat.sum_ok    = (~sum_q == rx_byte);
		stat.held_zero = (len_q == '0);
		stat.rd_last   = (rd_inc == len_q);
		stat.out_busy  = out_valid_q;
		stat.out_free  = !out_valid_q || out_ready;
	end

	// Output register is never overwritten while a word waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_load || cmd.empty_load) |-> (!out_valid_q || out_ready))
		else $error("output word overwritten");

	// Payload writes stay inside the buffer
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.data_load |-> (fill_q < DEPTH_LEN && fill_q < len_q))
		else $error("payload write beyond buffer");

	// Readout never passes the held length
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_load |-> (rd_q < len_q))
		else $error("readout beyond frame length");

endmodule

@@ src/packet_frame_receiver_top.sv @@
// Packet frame receiver top level: wires controller and datapath together.
// Depends on pfr_pkg, pfr_ctrl, pfr_dp (and pfr_ram through pfr_dp).
//
// Takes one received byte per input word and parses frames of the form
// first header, second header, device type, command, length, payload,
// checksum; the checksum is the inverted 8-bit sum of type through payload.
// Every byte before the checksum is taken at once. A good frame is then
// read out of the payload buffer, one output word per payload byte (or one
// word for an empty frame, marked by has_payload low), with last set on the
// frame's final word; bad or over-long frames produce nothing. The readout
// runs from a registered-read buffer, each word passing through a read-request
// state and a load state, and the input is held off until the frame's last
// word is loaded. The checksum byte is taken only once the output register is
// empty; all other bytes are taken while a word still waits at the output.
// Configuration writes act at once.
module packet_frame_receiver_top #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfr_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pfr_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pfr_pkg::BYTE_W-1:0]    device_type,
	output logic [pfr_pkg::BYTE_W-1:0]    command,
	output logic [pfr_pkg::LEN_W-1:0]     payload_length,
	output logic [pfr_pkg::IDX_W-1:0]     byte_index,
	output logic [pfr_pkg::BYTE_W-1:0]    payload_byte,
	output logic                          has_payload,
	output logic                          last
);
	import pfr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencing
	pfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.stat    (stat)
	);

	// Registers, buffer and output word
	pfr_dp #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.device_type   (device_type),
		.command       (command),
		.payload_length(payload_length),
		.byte_index    (byte_index),
		.payload_byte  (payload_byte),
		.has_payload   (has_payload),
		.last          (last)
	);

endmodule

@@ tb/packet_frame_receiver_top_tb.sv @@
// Self-checking testbench for packet_frame_receiver_top: byte-serial frame parsing,
// checksum, length limit and payload readout, with random stalls on both channels.
// Depends on pfr_pkg and the packet_frame_receiver_top RTL.
module packet_frame_receiver_top_tb;
	import pfr_pkg::*;

	localparam int BUF_DEPTH      = 64;
	localparam int DRAIN_CYCLES   = 2 * BUF_DEPTH + 40;
	localparam int SQUEEZE_CYCLES = 600;
	localparam int QUIET_LIMIT    = 5000;

	// One output word of an accepted frame
	typedef struct packed {
		logic [BYTE_W-1:0] device_type;
		logic [BYTE_W-1:0] command;
		logic [LEN_W-1:0]  payload_length;
		logic [IDX_W-1:0]  byte_index;
		logic [BYTE_W-1:0] payload_byte;
		logic              has_payload;
		logic              last;
	} frame_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [BYTE_W-1:0]    device_type;
	logic [BYTE_W-1:0]    command;
	logic [LEN_W-1:0]     payload_length;
	logic [IDX_W-1:0]     byte_index;
	logic [BYTE_W-1:0]    payload_byte;
	logic                 has_payload;
	logic                 last;

	// Stimulus and expected words
	logic [BYTE_W-1:0] rx_stream[$];
	logic [BYTE_W-1:0] body_bytes[$];
	frame_word_t       due_words[$];
	frame_word_t       seen_word;

	// Parser copy: registers and state
	logic [BYTE_W-1:0] hdr_first;
	logic [BYTE_W-1:0] hdr_second;
	logic [LEN_W-1:0]  len_cap;
	state_t            parse_st;
	logic [BYTE_W-1:0] run_sum;
	logic [BYTE_W-1:0] frame_type;
	logic [BYTE_W-1:0] frame_cmd;
	logic [LEN_W-1:0]  frame_len;
	logic [LEN_W-1:0]  fill_pos;
	logic [BYTE_W-1:0] frame_buf[BUF_DEPTH];

	// Handshake pacing
	bit idle_on;
	bit squeeze_req;
	bit squeeze_done;
	int send_gap;
	int stall_left;
	int squeeze_left;
	int quiet_cycles;

	// Run statistics
	int mismatches;
	int bytes_taken;
	int words_checked;
	int frames_kept;
	int frames_dropped;
	int settings_used;

	packet_frame_receiver_top #(
		.BUFFER_DEPTH(BUF_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.device_type(device_type),
		.command(command),
		.payload_length(payload_length),
		.byte_index(byte_index),
		.payload_byte(payload_byte),
		.has_payload(has_payload),
		.last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Length limit in force: max_length saturated to the buffer depth
	function automatic int len_limit();
		return (len_cap > BUF_DEPTH) ? BUF_DEPTH : int'(len_cap);
	endfunction

	// Parser model: advance on one byte, queue the words of a good frame
	function automatic void parse_byte(logic [BYTE_W-1:0] b);
		frame_word_t w;
		int k;
		case (parse_st)
			ST_HUNT1: begin
				if (b == hdr_first) parse_st = ST_HUNT2;
			end
			ST_HUNT2: begin
				if (b == hdr_second) parse_st = ST_TYPE;
				else if (b != hdr_first) parse_st = ST_HUNT1;
			end
			ST_TYPE: begin
				run_sum = b;
				frame_type = b;
				parse_st = ST_CMD;
			end
			ST_CMD: begin
				run_sum = run_sum + b;
				frame_cmd = b;
				parse_st = ST_LEN;
			end
			ST_LEN: begin
				run_sum = run_sum + b;
				fill_pos = '0;
				if (b > len_limit()) begin
					parse_st = ST_HUNT1;
					frames_dropped++;
				end else begin
					frame_len = b[LEN_W-1:0];
					parse_st = (b == 0) ? ST_SUM : ST_DATA;
				end
			end
			ST_DATA: begin
				run_sum = run_sum + b;
				if (fill_pos < BUF_DEPTH) frame_buf[fill_pos[IDX_W-1:0]] = b;
				fill_pos = fill_pos + 1'b1;
				if (fill_pos >= frame_len) parse_st = ST_SUM;
			end
			ST_SUM: begin
				if (BYTE_W'(~run_sum) == b) begin
					frames_kept++;
					if (frame_len == 0) begin
						w = '{frame_type, frame_cmd, '0, '0, '0, 1'b0, 1'b1};
						due_words.push_back(w);
					end else begin
						for (k = 0; k < frame_len; k++) begin
							w = '{frame_type, frame_cmd, frame_len, k[IDX_W-1:0],
								frame_buf[k], 1'b1, (k + 1 == frame_len)};
							due_words.push_back(w);
						end
					end
				end else begin
					frames_dropped++;
				end
				parse_st = ST_HUNT1;
			end
			default: parse_st = ST_HUNT1;
		endcase
	endfunction

	// Type, command, length, payload and checksum of one frame into body_bytes
	function automatic void frame_body(input logic [BYTE_W-1:0] typ, cmd, input int len,
			input int fill, input bit corrupt);
		logic [BYTE_W-1:0] csum;
		logic [BYTE_W-1:0] d;
		int i;
		body_bytes.delete();
		body_bytes.push_back(typ);
		body_bytes.push_back(cmd);
		body_bytes.push_back(len[BYTE_W-1:0]);
		csum = typ + cmd + len[BYTE_W-1:0];
		for (i = 0; i < len; i++) begin
			d = (fill < 0) ? BYTE_W'($urandom) : fill[BYTE_W-1:0];
			body_bytes.push_back(d);
			csum = csum + d;
		end
		if (corrupt) csum = csum ^ BYTE_W'(1 << $urandom_range(0, 7));
		body_bytes.push_back(~csum);
	endfunction

	// Queue a whole frame with the current headers; over-long ones stop at the length
	function automatic int add_frame(input logic [BYTE_W-1:0] typ, cmd, input int len,
			input int fill, input bit corrupt);
		int n;
		int i;
		frame_body(typ, cmd, len, fill, corrupt);
		n = (len > len_limit()) ? 3 : body_bytes.size();
		rx_stream.push_back(hdr_first);
		rx_stream.push_back(hdr_second);
		for (i = 0; i < n; i++) rx_stream.push_back(body_bytes[i]);
		return n + 2;
	endfunction

	// Mostly short payloads, now and then the full limit or an over-long length
	function automatic int pick_len(int lim);
		int r;
		r = $urandom_range(0, 29);
		if (r < 20) return $urandom_range(0, (lim < 6) ? lim : 6);
		if (r < 27) return $urandom_range(0, (lim < 16) ? lim : 16);
		if (r == 27) return lim;
		return $urandom_range(lim + 1, 255);
	endfunction

	// Random frames with noise and cut-off frames mixed in
	task automatic random_traffic(int budget);
		int sent;
		int pick;
		int n;
		int i;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 19);
			if (pick < 2) begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++) rx_stream.push_back(BYTE_W'($urandom));
				sent += n;
			end else if (pick < 4) begin
				frame_body(BYTE_W'($urandom), BYTE_W'($urandom), pick_len(len_limit()), -1,
					1'b0);
				n = $urandom_range(0, body_bytes.size() - 1);
				rx_stream.push_back(hdr_first);
				rx_stream.push_back(hdr_second);
				for (i = 0; i < n; i++) rx_stream.push_back(body_bytes[i]);
				sent += n + 2;
			end else begin
				if (pick == 4) begin
					n = $urandom_range(1, 3);
					for (i = 0; i < n; i++) rx_stream.push_back(hdr_first);
				end
				sent += add_frame(BYTE_W'($urandom), BYTE_W'($urandom),
					pick_len(len_limit()), -1, $urandom_range(0, 7) == 0);
			end
		end
	endtask

	// Write all three registers back to back, then update the model copy
	task automatic program_regs(input logic [BYTE_W-1:0] a, b, m);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FIRST_HEADER;
		cfg_data <= a;
		@(posedge clk);
		cfg_index <= CFG_SECOND_HEADER;
		cfg_data <= b;
		@(posedge clk);
		cfg_index <= CFG_MAX_LENGTH;
		cfg_data <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		hdr_first = a;
		hdr_second = b;
		len_cap = m[LEN_W-1:0];
		settings_used++;
	endtask

	// Wait until every byte is in and every due word is out, then let readout finish
	task automatic settle();
		while (rx_stream.size() != 0 || in_valid || due_words.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= 40) $display("%0t mismatch: %s", $time, what);
	endtask

	task automatic check_word(frame_word_t got);
		frame_word_t want;
		if (due_words.size() == 0) begin
			report_mismatch($sformatf("word with nothing due: type %02h cmd %02h index %0d",
				got.device_type, got.command, got.byte_index));
		end else begin
			want = due_words.pop_front();
			if (got.device_type !== want.device_type)
				report_mismatch($sformatf("device_type %02h, want %02h",
					got.device_type, want.device_type));
			if (got.command !== want.command)
				report_mismatch($sformatf("command %02h, want %02h",
					got.command, want.command));
			if (got.payload_length !== want.payload_length)
				report_mismatch($sformatf("payload_length %0d, want %0d",
					got.payload_length, want.payload_length));
			if (got.byte_index !== want.byte_index)
				report_mismatch($sformatf("byte_index %0d, want %0d",
					got.byte_index, want.byte_index));
			if (got.payload_byte !== want.payload_byte)
				report_mismatch($sformatf("payload_byte %02h, want %02h at index %0d",
					got.payload_byte, want.payload_byte, want.byte_index));
			if (got.has_payload !== want.has_payload)
				report_mismatch($sformatf("has_payload %b, want %b",
					got.has_payload, want.has_payload));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %b, want %b at index %0d",
					got.last, want.last, want.byte_index));
		end
		words_checked++;
	endtask

	// Byte driver: feeds rx_stream, random gaps while idling is on
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				parse_byte(rx_byte);
				bytes_taken++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (rx_stream.size() != 0 && idle_on && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 13);
					in_valid <= 1'b0;
				end else if (rx_stream.size() != 0) begin
					in_valid <= 1'b1;
					rx_byte <= rx_stream.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Word monitor: checks taken words, one long hold-off, random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				seen_word = '{device_type, command, payload_length, byte_index,
					payload_byte, has_payload, last};
				check_word(seen_word);
			end
			if (squeeze_req && !squeeze_done) begin
				squeeze_left = SQUEEZE_CYCLES;
				squeeze_done = 1'b1;
			end
			if (squeeze_left > 0) begin
				squeeze_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 13);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without a word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FIRST_HEADER;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		out_ready = 1'b0;
		hdr_first = FIRST_HEADER_RST;
		hdr_second = SECOND_HEADER_RST;
		len_cap = MAX_LENGTH_RST;
		parse_st = ST_HUNT1;
		run_sum = '0;
		frame_type = '0;
		frame_cmd = '0;
		frame_len = '0;
		fill_pos = '0;
		idle_on = 1'b1;
		squeeze_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset register values: empty frame, repeated first header, restart of the hunt
		void'(add_frame(8'h00, 8'hFF, 0, -1, 1'b0));
		rx_stream.push_back(hdr_first);
		rx_stream.push_back(hdr_first);
		void'(add_frame(8'hFF, 8'h00, 1, 8'hFF, 1'b0));
		rx_stream.push_back(hdr_first);
		rx_stream.push_back(8'h12);
		// over-long length, then a frame right behind it; then a bad checksum
		void'(add_frame(8'h5A, 8'h01, BUF_DEPTH + 1, -1, 1'b0));
		void'(add_frame(8'h5A, 8'h02, 2, 8'h00, 1'b0));
		void'(add_frame(8'h33, 8'h44, 2, -1, 1'b1));
		settle();

		// Zero length cap, extreme header values
		program_regs(8'h00, 8'hFF, 8'h00);
		void'(add_frame(8'hA5, 8'h5A, 0, -1, 1'b0));
		void'(add_frame(8'h01, 8'h02, 1, -1, 1'b0));
		void'(add_frame(8'hFE, 8'hEF, 0, -1, 1'b1));
		settle();

		// Cap above the buffer (bit 7 of the write dropped), equal headers, full buffer
		program_regs(8'h7E, 8'h7E, 8'hFF);
		void'(add_frame(8'h11, 8'h22, BUF_DEPTH, -1, 1'b0));
		void'(add_frame(8'h11, 8'h23, BUF_DEPTH + 1, -1, 1'b0));
		void'(add_frame(8'h11, 8'h24, 3, -1, 1'b0));
		settle();

		// Header registers changed while waiting for the second header
		rx_stream.push_back(hdr_first);
		settle();
		program_regs(8'h3C, 8'hC3, 8'd3);
		rx_stream.push_back(hdr_first);
		rx_stream.push_back(hdr_second);
		frame_body(8'h66, 8'h77, 3, -1, 1'b0);
		for (i = 0; i < body_bytes.size(); i++) rx_stream.push_back(body_bytes[i]);
		// cap lowered between command and length byte
		frame_body(8'h66, 8'h78, 3, -1, 1'b0);
		rx_stream.push_back(hdr_first);
		rx_stream.push_back(hdr_second);
		rx_stream.push_back(body_bytes[0]);
		rx_stream.push_back(body_bytes[1]);
		settle();
		program_regs(8'h3C, 8'hC3, 8'd2);
		for (i = 2; i < body_bytes.size(); i++) rx_stream.push_back(body_bytes[i]);
		settle();

		// Random traffic; the receiver holds off at the start so the input backs up
		squeeze_req = 1'b1;
		program_regs(BYTE_W'($urandom), BYTE_W'($urandom), 8'd64);
		random_traffic(50);
		settle();
		program_regs(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom_range(1, 10)));
		random_traffic(40);
		settle();
		program_regs(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom_range(65, 255)));
		random_traffic(40);
		while (rx_stream.size() != 0) @(negedge clk);
		// closing stretch at full rate
		idle_on = 1'b0;
		random_traffic(40);
		settle();

		while (due_words.size() != 0) begin
			report_mismatch("word still due at end of run");
			void'(due_words.pop_front());
		end
		$display("Run covered %0d bytes in %0d register settings: %0d frames kept, %0d dropped.",
			bytes_taken, settings_used, frames_kept, frames_dropped);
		$display("Checked %0d output words, %0d mismatches.", words_checked, mismatches);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
